@@ rtl/ccrc_pkg.sv @@
// shared types, opcodes and crc helper for the chunked crc-32 engine
package ccrc_pkg;

    localparam int LEN_W   = 25;
    localparam int CNT_W   = 16;
    localparam int CRC_W   = 32;
    localparam int TOT_W   = 32;
    localparam int OP_W    = 2;
    localparam int BYTE_W  = 8;

    localparam logic [CRC_W-1:0] CRC_POLY   = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] CRC_INIT   = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0] CRC_XOROUT = 32'hFFFF_FFFF;

    localparam logic [LEN_W-1:0] CHUNK_LENGTH_RST = 25'd1024;
    localparam logic [CNT_W-1:0] MAX_CHUNKS_RST   = 16'd256;

    // opcodes of the input beat
    localparam logic [OP_W-1:0] OP_DATA   = 2'd0;
    localparam logic [OP_W-1:0] OP_FINISH = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    // configuration register indexes
    localparam logic CFG_CHUNK_LENGTH = 1'b0;
    localparam logic CFG_MAX_CHUNKS   = 1'b1;

    // status codes
    localparam logic ST_CRC   = 1'b0;
    localparam logic ST_ERROR = 1'b1;

    // one result beat
    typedef struct packed {
        logic [TOT_W-1:0] bytes_so_far;
        logic [CNT_W-1:0] chunk_index;
        logic [CRC_W-1:0] chunk_crc;
        logic             status;
    } ccrc_result_t;

    // reflected crc-32 update by one byte, unrolled into xor logic
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int i = 0; i < BYTE_W; i++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : {CRC_W{1'b0}});
        end
        return c;
    endfunction

endpackage

@@ rtl/chunked_crc32_engine.sv @@
// top level of the chunked crc-32 engine
// result beats are registered toward the master side, via the skid register on a stall
// throughput: one input beat per cycle while s_tready is high, via combinational crc update
// while the master side stalls, input keeps accepting until a second result beat waits
// reset: synchronous active-low aresetn clears chunk state and output valids,
// chunk_length returns to 1024 and max_chunks to 256
module chunked_crc32_engine (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [24:0] cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic [1:0]  s_tuser,    // [1:0] opcode
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,    // [31:0] chunk_crc, [47:32] chunk_index, [79:48] bytes_so_far
    output logic        m_tuser     // [0] status
);
    import ccrc_pkg::*;

    logic         accept;
    logic         res_valid;
    ccrc_result_t res;
    ccrc_result_t out_res;

    assign accept = s_tvalid && s_tready;

    ccrc_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .opcode    (s_tuser),
        .data_byte (s_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    ccrc_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_res    (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_res   (out_res),
        .out_ready (m_tready)
    );

    // pack result beat
    assign m_tdata = {out_res.bytes_so_far, out_res.chunk_index, out_res.chunk_crc};
    assign m_tuser = out_res.status;

endmodule

@@ rtl/ccrc_core.sv @@
// chunk state, configuration registers and per-beat crc update
module ccrc_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [ccrc_pkg::LEN_W-1:0]  cfg_data,
    input  logic                        accept,
    input  logic [ccrc_pkg::OP_W-1:0]   opcode,
    input  logic [ccrc_pkg::BYTE_W-1:0] data_byte,
    output logic                        res_valid,
    output ccrc_pkg::ccrc_result_t      res
);
    import ccrc_pkg::*;

    logic [LEN_W-1:0] chunk_length_reg;
    logic [CNT_W-1:0] max_chunks_reg;

    logic [CRC_W-1:0] crc_reg,         crc_next;
    logic [LEN_W-1:0] chunk_fill_reg,  chunk_fill_next;
    logic [CNT_W-1:0] chunk_count_reg, chunk_count_next;
    logic [TOT_W-1:0] total_count_reg, total_count_next;

    logic [CRC_W-1:0] crc_upd;
    logic [LEN_W-1:0] fill_inc;
    logic [TOT_W-1:0] total_inc;
    logic             at_capacity;
    logic             fill_full;
    logic             fill_inc_full;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chunk_length_reg <= CHUNK_LENGTH_RST;
            max_chunks_reg   <= MAX_CHUNKS_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_CHUNK_LENGTH: chunk_length_reg <= cfg_data;
                CFG_MAX_CHUNKS:   max_chunks_reg   <= cfg_data[CNT_W-1:0];
                default:          ;
            endcase
        end
    end

    // shared terms
    assign crc_upd       = crc_byte(crc_reg, data_byte);
    assign fill_inc      = chunk_fill_reg + 1'b1;
    assign total_inc     = total_count_reg + 1'b1;
    assign at_capacity   = chunk_count_reg >= max_chunks_reg;
    assign fill_full     = chunk_fill_reg >= chunk_length_reg;
    assign fill_inc_full = fill_inc >= chunk_length_reg;

    // next state and result for one beat
    always_comb begin
        crc_next         = crc_reg;
        chunk_fill_next  = chunk_fill_reg;
        chunk_count_next = chunk_count_reg;
        total_count_next = total_count_reg;
        res_valid        = 1'b0;
        res.status       = ST_ERROR;
        res.chunk_crc    = '0;
        res.chunk_index  = chunk_count_reg;
        res.bytes_so_far = total_count_reg;
        if (accept) begin
            unique case (opcode)
                OP_DATA: begin
                    if (at_capacity && fill_full) begin
                        // locked: drop the byte, report error
                        res_valid = 1'b1;
                    end else begin
                        crc_next         = crc_upd;
                        chunk_fill_next  = fill_inc;
                        total_count_next = total_inc;
                        res.bytes_so_far = total_inc;
                        if (fill_inc_full) begin
                            res_valid = 1'b1;
                            if (!at_capacity) begin
                                res.status       = ST_CRC;
                                res.chunk_crc    = crc_upd ^ CRC_XOROUT;
                                chunk_count_next = chunk_count_reg + 1'b1;
                                chunk_fill_next  = '0;
                                crc_next         = CRC_INIT;
                            end
                        end
                    end
                end
                OP_FINISH: begin
                    // partial chunk closes only if it holds bytes
                    if (chunk_fill_reg != '0) begin
                        res_valid = 1'b1;
                        if (!at_capacity) begin
                            res.status       = ST_CRC;
                            res.chunk_crc    = crc_reg ^ CRC_XOROUT;
                            chunk_count_next = chunk_count_reg + 1'b1;
                            chunk_fill_next  = '0;
                            crc_next         = CRC_INIT;
                        end
                    end
                end
                OP_CLEAR: begin
                    crc_next         = CRC_INIT;
                    chunk_fill_next  = '0;
                    chunk_count_next = '0;
                    total_count_next = '0;
                end
                default: ;
            endcase
        end
    end

    // chunk state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg         <= CRC_INIT;
            chunk_fill_reg  <= '0;
            chunk_count_reg <= '0;
            total_count_reg <= '0;
        end else begin
            crc_reg         <= crc_next;
            chunk_fill_reg  <= chunk_fill_next;
            chunk_count_reg <= chunk_count_next;
            total_count_reg <= total_count_next;
        end
    end

endmodule

@@ rtl/ccrc_out_buf.sv @@
// result register with skid stage toward the master side
module ccrc_out_buf (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    input  ccrc_pkg::ccrc_result_t in_res,
    output logic                   in_ready,
    output logic                   out_valid,
    output ccrc_pkg::ccrc_result_t out_res,
    input  logic                   out_ready
);
    import ccrc_pkg::*;

    logic         out_valid_reg,  out_valid_next;
    logic         skid_valid_reg, skid_valid_next;
    ccrc_result_t out_res_reg,    out_res_next;
    ccrc_result_t skid_res_reg,   skid_res_next;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    // move beats through output and skid registers
    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_res_next    = out_res_reg;
        skid_res_next   = skid_res_reg;
        if (out_ready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_res_next    = skid_res_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = in_valid;
                out_res_next   = in_res;
            end
        end else if (in_valid && !skid_valid_reg) begin
            skid_valid_next = 1'b1;
            skid_res_next   = in_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

endmodule
